### src/jha_pkg.sv
package jha_pkg;

    localparam int MAX_LABELS  = 256;
    localparam int MAX_COLUMNS = 16;
    localparam int COUNT_BITS  = 32;

    localparam int LABEL_BITS  = 9;
    localparam int COLUMN_BITS = 5;
    localparam int CMD_BITS    = 2;
    localparam int OUT_BITS    = 32;
    localparam int CFG_BITS    = 9;

    localparam int ROW_BITS    = $clog2(MAX_LABELS);
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [CMD_BITS-1:0] CMD_ACCUM      = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ       = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ_CLEAR = 2'd2;

    localparam logic REG_NUM_LABELS  = 1'b0;
    localparam logic REG_NUM_COLUMNS = 1'b1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // One classified request on its way from the front end to the back end.
    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [ADDR_BITS-1:0] slot;
        logic                 error;
    } work_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

### src/jha_queue.sv
module jha_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  jha_pkg::work_t push_item,
    output logic           full,
    input  logic           pop,
    output jha_pkg::work_t head,
    output logic           empty
);
    import jha_pkg::*;

    work_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg;
    logic [QPTR_BITS:0]   fill_next;

    assign full  = (fill_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/jha_front.sv
module jha_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [jha_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,
    input  jha_pkg::back_status_t         back_status,
    input  logic                          q_full,
    output logic                          push,
    output jha_pkg::work_t                push_item
);
    import jha_pkg::*;

    logic [LABEL_BITS-1:0]  num_labels_reg;
    logic [COLUMN_BITS-1:0] num_columns_reg;

    logic [CMD_BITS-1:0]    command;
    logic [LABEL_BITS-1:0]  label;
    logic [COLUMN_BITS-1:0] column;
    logic [LABEL_BITS-1:0]  lab_lim;
    logic [COLUMN_BITS-1:0] col_lim;
    logic [LABEL_BITS-1:0]  label_m1;
    logic [COLUMN_BITS-1:0] column_m1;

    assign command = s_tdata[CMD_BITS-1:0];
    assign label   = s_tdata[CMD_BITS +: LABEL_BITS];
    assign column  = s_tdata[CMD_BITS+LABEL_BITS +: COLUMN_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_labels_reg  <= LABEL_BITS'(MAX_LABELS);
            num_columns_reg <= COLUMN_BITS'(MAX_COLUMNS);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_NUM_LABELS) begin
                num_labels_reg <= cfg_wdata[LABEL_BITS-1:0];
            end else begin
                num_columns_reg <= cfg_wdata[COLUMN_BITS-1:0];
            end
        end
    end

    // A register set above the table size is clamped to the table size.
    always_comb begin
        lab_lim = (num_labels_reg < LABEL_BITS'(MAX_LABELS)) ?
                  num_labels_reg : LABEL_BITS'(MAX_LABELS);
        col_lim = (num_columns_reg < COLUMN_BITS'(MAX_COLUMNS)) ?
                  num_columns_reg : COLUMN_BITS'(MAX_COLUMNS);
    end

    assign label_m1  = label - 1'b1;
    assign column_m1 = column - 1'b1;

    always_comb begin
        push_item.command = command;
        push_item.slot    = {label_m1[ROW_BITS-1:0], column_m1[COL_BITS-1:0]};
        push_item.error   = (label == '0) || (label > lab_lim) ||
                            (column == '0) || (column > col_lim);
    end

    assign s_tready = !q_full && !back_status.clearing;
    assign push     = s_tvalid && s_tready;

endmodule

### src/jha_back.sv
module jha_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  jha_pkg::work_t                head,
    input  logic                          q_empty,
    output logic                          pop,
    output jha_pkg::back_status_t         back_status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jha_pkg::OUT_BITS-1:0]  m_tdata,
    output logic                          m_tuser
);
    import jha_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [ADDR_BITS-1:0]   clr_addr_reg;
    work_t                  cur_reg;

    logic [COUNT_BITS-1:0]  mem [MAX_LABELS*MAX_COLUMNS];
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic                   mem_we;
    logic [ADDR_BITS-1:0]   mem_waddr;
    logic [COUNT_BITS-1:0]  mem_wdata;

    logic                   out_valid_reg;
    logic [OUT_BITS-1:0]    out_count_reg;
    logic                   out_error_reg;

    logic                   out_free;
    logic                   finish;
    logic [COUNT_BITS-1:0]  new_value;

    assign out_free = !out_valid_reg || m_tready;
    assign finish   = (state_reg == ST_UPDATE) && out_free;
    assign pop      = (state_reg == ST_IDLE) && !q_empty;

    assign back_status.clearing = (state_reg == ST_CLEAR);

    assign new_value = (rd_data_reg == COUNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg.slot;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end else if (finish && !cur_reg.error) begin
            if (cur_reg.command == CMD_ACCUM) begin
                mem_we    = 1'b1;
                mem_wdata = new_value;
            end else if (cur_reg.command == CMD_READ_CLEAR) begin
                mem_we = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
        if (finish) begin
            out_error_reg <= cur_reg.error;
            if (cur_reg.error) begin
                out_count_reg <= '0;
            end else if (cur_reg.command == CMD_ACCUM) begin
                out_count_reg <= new_value[OUT_BITS-1:0];
            end else begin
                out_count_reg <= rd_data_reg[OUT_BITS-1:0];
            end
        end
    end

    // The bin is read only when its request is taken, so the count holds
    // while the result register is stalled.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            rd_data_reg <= mem[head.slot];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_error_reg;

endmodule

### src/joint_histogram_accumulator.sv
// Two-dimensional histogram of 32-bit bin counts, 256 label rows by 16 columns,
// addressed by a 1-based label and a 1-based column. Each request yields one
// result: an accumulate request adds one to the bin (saturating) and returns
// the new count, a read request returns the count, and a read-and-clear
// request returns the count and zeroes the bin. A label or column of zero or
// beyond the configured sizes leaves the table alone and returns count 0 with
// the error flag set in m_tuser. After reset the block runs a clearing pass
// over all 4096 bins of the memory, one bin per cycle, with s_tready held low;
// configuration writes are taken during that pass. After it, the back end
// reads each request's bin from the single bin memory as it takes the request
// from the queue, then updates, writes back and registers the result once the
// result register is free, and takes no new request before that. A four-entry
// queue between the front and back ends takes up to four more requests while
// a result waits on m_tready; when full, it holds s_tready low until one leaves.
module joint_histogram_accumulator (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: index 0 is num_labels, index 1 is num_columns.
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [jha_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0 up: command[1:0], label[10:2], column[15:11].
    input  logic [15:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0 up: count[31:0].
    output logic [jha_pkg::OUT_BITS-1:0]  m_tdata,
    // m_tuser fields from bit 0 up: error[0].
    output logic                          m_tuser
);
    import jha_pkg::*;

    work_t        push_item;
    work_t        head;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    back_status_t back_status;

    // The front end holds the size registers, checks each request against
    // them and forms the bin address.
    jha_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .back_status (back_status),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    // Classified requests wait here until the back end is free.
    jha_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    // The back end owns the bin memory, its clearing pass and the result
    // register.
    jha_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
